[src/nnf_pkg.sv]
// Package for the note name to frequency block: shared types, codes and tables.
// No dependencies; imported by every module under src.
package nnf_pkg;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned SEMI_W   = 4;
    localparam int unsigned OFS_W    = 6;
    localparam int unsigned DIG_W    = 8;
    localparam int unsigned BASE_W   = 15;
    localparam int unsigned FREQ_W   = 22;
    localparam int unsigned OCT_W    = 10;
    localparam int unsigned SHIFT_W  = 3;
    localparam int unsigned NOTES    = 12;

    // Characters the parser looks for
    localparam logic [CHAR_W-1:0] CH_SHARP = 8'h23;
    localparam logic [CHAR_W-1:0] CH_FLAT  = 8'h62;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_G  = 8'h47;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_BIT = 8'h20;

    localparam logic [SEMI_W-1:0] SEMI_TOP   = 4'd11;
    localparam logic [DIG_W-1:0]  DIG_MAX    = 8'd255;
    localparam logic [OCT_W-1:0]  OCT_DEF    = 10'd4;
    localparam logic [OCT_W-1:0]  OCT_LO     = 10'd1;
    localparam logic [OCT_W-1:0]  OCT_HI     = 10'd8;

    // Parsed note, handed from the parser to the frequency stage
    typedef struct packed {
        logic [SEMI_W-1:0]       semi;
        logic signed [OFS_W-1:0] ofs;
        logic [DIG_W-1:0]        dig;
        logic                    neg;
        logic                    bad;
    } t_note;

    // Semitone above A for letters A..G
    function automatic logic [SEMI_W-1:0] letter_semi(input logic [2:0] idx);
        logic [SEMI_W-1:0] s;
        unique case (idx)
            3'd0:    s = 4'd0;
            3'd1:    s = 4'd2;
            3'd2:    s = 4'd3;
            3'd3:    s = 4'd5;
            3'd4:    s = 4'd7;
            3'd5:    s = 4'd8;
            3'd6:    s = 4'd10;
            default: s = 4'd0;
        endcase
        return s;
    endfunction

    // round(55 * 2^(i/12) * 256), octave 1
    function automatic logic [BASE_W-1:0] base_q8(input logic [SEMI_W-1:0] idx);
        logic [BASE_W-1:0] b;
        unique case (idx)
            4'd0:    b = 15'd14080;
            4'd1:    b = 15'd14917;
            4'd2:    b = 15'd15804;
            4'd3:    b = 15'd16744;
            4'd4:    b = 15'd17740;
            4'd5:    b = 15'd18795;
            4'd6:    b = 15'd19912;
            4'd7:    b = 15'd21096;
            4'd8:    b = 15'd22351;
            4'd9:    b = 15'd23680;
            4'd10:   b = 15'd25088;
            4'd11:   b = 15'd26580;
            default: b = '0;
        endcase
        return b;
    endfunction

endpackage

[src/nnf_parser.sv]
// Character parser: letter, accidentals, then an atoi-style octave number.
// Depends on nnf_pkg. Gives the finished note when the last character is taken.
module nnf_parser
    import nnf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic              i_last,
    input  logic [CHAR_W-1:0] i_ch,
    output t_note             o_note
);

    localparam logic [2:0] PH_LETTER = 3'd0;
    localparam logic [2:0] PH_ACCID  = 3'd1;
    localparam logic [2:0] PH_SPACE  = 3'd2;
    localparam logic [2:0] PH_DIGITS = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    localparam logic signed [OFS_W-1:0] OFS_MAX = 6'sd31;
    localparam logic signed [OFS_W-1:0] OFS_MIN = -6'sd32;

    logic [2:0]              r_phase, n_phase;
    logic [SEMI_W-1:0]       r_semi, n_semi;
    logic signed [OFS_W-1:0] r_ofs, n_ofs;
    logic [DIG_W-1:0]        r_dig, n_dig;
    logic                    r_neg, n_neg;
    logic                    r_bad, n_bad;

    logic [CHAR_W-1:0] up_ch;
    logic              is_letter, is_digit, is_ws, is_sign;
    logic [11:0]       dig_sum;
    logic [DIG_W-1:0]  dig_sat;
    logic              do_oct;
    logic [2:0]        oct_phase;

    // Character classes
    always_comb begin
        up_ch     = (i_ch >= CH_LO_A && i_ch <= CH_LO_Z) ? (i_ch - CASE_BIT) : i_ch;
        is_letter = up_ch >= CH_UP_A && up_ch <= CH_UP_G;
        is_digit  = i_ch >= CH_ZERO && i_ch <= CH_NINE;
        is_ws     = i_ch == CH_SPACE || (i_ch >= CH_TAB && i_ch <= CH_CR);
        is_sign   = i_ch == CH_PLUS || i_ch == CH_MINUS;
        // digits * 10 + new digit, saturating
        dig_sum   = ({4'd0, r_dig} << 3) + ({4'd0, r_dig} << 1)
                  + {4'd0, i_ch - CH_ZERO};
        dig_sat   = (dig_sum > {4'd0, DIG_MAX}) ? DIG_MAX : dig_sum[DIG_W-1:0];
    end

    // Next parser state
    always_comb begin
        n_phase   = r_phase;
        n_semi    = r_semi;
        n_ofs     = r_ofs;
        n_dig     = r_dig;
        n_neg     = r_neg;
        n_bad     = r_bad;
        do_oct    = 1'b0;
        oct_phase = r_phase;
        unique case (r_phase)
            PH_LETTER: begin
                if (is_letter) begin
                    n_semi  = letter_semi(up_ch[2:0] - 3'd1);
                    n_phase = PH_ACCID;
                end else begin
                    n_bad   = 1'b1;
                    n_phase = PH_DONE;
                end
            end
            PH_ACCID: begin
                if (i_ch == CH_SHARP) begin
                    if (r_semi >= SEMI_TOP) begin
                        n_semi = '0;
                        if (r_ofs != OFS_MAX) n_ofs = r_ofs + 6'sd1;
                    end else begin
                        n_semi = r_semi + 4'd1;
                    end
                end else if (i_ch == CH_FLAT) begin
                    if (r_semi == '0) begin
                        n_semi = SEMI_TOP;
                        if (r_ofs != OFS_MIN) n_ofs = r_ofs - 6'sd1;
                    end else begin
                        n_semi = r_semi - 4'd1;
                    end
                end else begin
                    n_phase   = PH_SPACE;
                    oct_phase = PH_SPACE;
                    do_oct    = 1'b1;
                end
            end
            PH_SPACE, PH_DIGITS: begin
                do_oct = 1'b1;
            end
            default: begin
            end
        endcase

        // Octave number, read like atoi
        if (do_oct) begin
            if (oct_phase == PH_SPACE) begin
                if (is_ws) begin
                end else if (is_sign) begin
                    n_neg   = i_ch == CH_MINUS;
                    n_phase = PH_DIGITS;
                end else if (is_digit) begin
                    n_dig   = dig_sat;
                    n_phase = PH_DIGITS;
                end else begin
                    n_phase = PH_DONE;
                end
            end else begin
                if (is_digit) n_dig   = dig_sat;
                else          n_phase = PH_DONE;
            end
        end
    end

    // State registers; cleared after the last character of a name
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last)) begin
            r_phase <= PH_LETTER;
            r_semi  <= '0;
            r_ofs   <= '0;
            r_dig   <= '0;
            r_neg   <= 1'b0;
            r_bad   <= 1'b0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_semi  <= n_semi;
            r_ofs   <= n_ofs;
            r_dig   <= n_dig;
            r_neg   <= n_neg;
            r_bad   <= n_bad;
        end
    end

    assign o_note = '{semi: n_semi, ofs: n_ofs, dig: n_dig, neg: n_neg, bad: n_bad};

endmodule

[src/nnf_freq.sv]
// Frequency stage: resolves the octave, clamps it and shifts the base table entry.
// Depends on nnf_pkg.
module nnf_freq
    import nnf_pkg::*;
(
    input  t_note             i_note,
    output logic [FREQ_W-1:0] o_freq,
    output logic              o_valid_res
);

    logic signed [OCT_W-1:0] oct_raw, oct_sum;
    logic [SHIFT_W-1:0]      shift;

    always_comb begin
        // Octave 0 or none means 4
        if (i_note.dig == '0)   oct_raw = OCT_DEF;
        else if (i_note.neg)    oct_raw = -$signed({2'b00, i_note.dig});
        else                    oct_raw = $signed({2'b00, i_note.dig});
        oct_sum = oct_raw + OCT_W'(i_note.ofs);

        // Clamp to 1..8, shift by octave - 1
        if (oct_sum < $signed(OCT_LO))      shift = '0;
        else if (oct_sum > $signed(OCT_HI)) shift = 3'd7;
        else                                shift = SHIFT_W'(oct_sum - $signed(OCT_LO));

        if (i_note.bad) begin
            o_freq      = '0;
            o_valid_res = 1'b0;
        end else begin
            o_freq      = {{(FREQ_W-BASE_W){1'b0}}, base_q8(i_note.semi)} << shift;
            o_valid_res = 1'b1;
        end
    end

endmodule

[src/note_name_to_frequency.sv]
// Takes one character per cycle, unless the input is stalled, and on the final
// character gives the note's frequency in UQ14.8 hertz. The final character's
// note is held in a note register; the frequency computed from it is then
// registered in the output register when the output slot is free. While the
// output is held, the note register keeps its note. The input stalls only
// when the note register and the output register are both full.
// Depends on nnf_pkg, nnf_parser and nnf_freq.
module note_name_to_frequency
    import nnf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [7:0]        i_s_axis_tdata,   // [7:0] ch
    input  logic              i_s_axis_tlast,   // last
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [23:0]       o_m_axis_tdata,   // [21:0] freq_q8, [23:22] zero
    output logic              o_m_axis_tuser    // valid_res
);

    logic              take, adv_out, stage_free;
    t_note             note_next;
    t_note             r_note;
    logic              r_p_valid;
    logic [FREQ_W-1:0] freq;
    logic              valid_res;
    logic              r_o_valid;
    logic [FREQ_W-1:0] r_freq;
    logic              r_valid_res;

    // Handshake: both stages move when the output slot is free
    assign adv_out         = !r_o_valid || i_m_axis_tready;
    assign stage_free      = !r_p_valid || adv_out;
    assign o_s_axis_tready = stage_free;
    assign take            = i_s_axis_tvalid && stage_free;

    nnf_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_last  (i_s_axis_tlast),
        .i_ch    (i_s_axis_tdata[CHAR_W-1:0]),
        .o_note  (note_next)
    );

    // Finished note register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (take && i_s_axis_tlast) begin
            r_p_valid <= 1'b1;
        end else if (adv_out) begin
            r_p_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_s_axis_tlast) begin
            r_note <= note_next;
        end
    end

    nnf_freq u_freq (
        .i_note      (r_note),
        .o_freq      (freq),
        .o_valid_res (valid_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (adv_out) begin
            r_o_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_out && r_p_valid) begin
            r_freq      <= freq;
            r_valid_res <= valid_res;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {2'b00, r_freq};
    assign o_m_axis_tuser  = r_valid_res;

    // A final character always fills the note register
    a_last_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && i_s_axis_tlast |=> r_p_valid)
        else $error("note register not loaded after final character");

    // Held note keeps a semitone in range
    a_semi_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_valid |-> r_note.semi <= SEMI_TOP)
        else $error("semitone out of range");

    // Invalid result carries zero frequency
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("invalid note with nonzero frequency");

    // Valid result always carries a nonzero frequency
    a_good_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata != '0)
        else $error("valid note with zero frequency");

endmodule

[verif/tb.sv]
// Testbench for note_name_to_frequency: streams note-name characters through the
// block and checks every frequency result against an in-bench note parser.
// Depends on nnf_pkg and the RTL under src; needs no files or arguments.
module tb
    import nnf_pkg::*;
();

    // Parser position within one note name
    typedef enum logic [2:0] {
        P_LETTER,
        P_ACCID,
        P_SPACE,
        P_DIGITS,
        P_DONE
    } t_name_phase;

    // One predicted result
    typedef struct {
        logic [FREQ_W-1:0] freq;
        logic              ok;
    } t_pitch;

    localparam int OFS_FLOOR = -32;
    localparam int OFS_CEIL  = 31;

    // Semitones above A for A..G, and the octave-1 pitches in UQ7.8
    localparam logic [3:0]  STEP_FROM_A [7]  = '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10};
    localparam logic [14:0] A1_Q8       [12] = '{15'd14080, 15'd14917, 15'd15804, 15'd16744,
                                                 15'd17740, 15'd18795, 15'd19912, 15'd21096,
                                                 15'd22351, 15'd23680, 15'd25088, 15'd26580};

    // Parses characters as they are accepted and queues the expected pitches
    class t_pitch_board;
        t_name_phase phase;
        logic [3:0]  semi;
        int          ofs;
        int          digs;
        bit          neg;
        bit          bad;
        t_pitch      pending[$];
        int          errors;
        int          good_notes;
        int          bad_names;

        function new();
            restart();
            errors     = 0;
            good_notes = 0;
            bad_names  = 0;
        endfunction

        function void restart();
            phase = P_LETTER;
            semi  = '0;
            ofs   = 0;
            digs  = 0;
            neg   = 1'b0;
            bad   = 1'b0;
        endfunction

        // atoi-style octave: white space, sign, then digits
        function void octave_char(logic [7:0] c);
            bit is_num;
            is_num = (c >= CH_ZERO && c <= CH_NINE);
            if (phase == P_SPACE) begin
                if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
                    return;
                end
                if (c == CH_PLUS || c == CH_MINUS) begin
                    neg   = (c == CH_MINUS);
                    phase = P_DIGITS;
                    return;
                end
                phase = is_num ? P_DIGITS : P_DONE;
            end else if (phase == P_DIGITS) begin
                if (!is_num) begin
                    phase = P_DONE;
                end
            end else begin
                return;
            end
            // octave digit value saturates
            if (phase == P_DIGITS) begin
                digs = digs * 10 + int'(c - CH_ZERO);
                if (digs > int'(DIG_MAX)) begin
                    digs = int'(DIG_MAX);
                end
            end
        endfunction

        function void note_char(logic [7:0] c, logic last);
            logic [7:0]  up;
            int          oct;
            logic [31:0] hz;
            t_pitch      p;
            case (phase)
                P_LETTER: begin
                    up = (c >= CH_LO_A && c <= CH_LO_Z) ? c - CASE_BIT : c;
                    if (up >= CH_UP_A && up <= CH_UP_G) begin
                        semi  = STEP_FROM_A[up - CH_UP_A];
                        phase = P_ACCID;
                    end else begin
                        bad   = 1'b1;
                        phase = P_DONE;
                    end
                end
                P_ACCID: begin
                    if (c == CH_SHARP) begin
                        if (semi >= SEMI_TOP) begin
                            semi = '0;
                            if (ofs < OFS_CEIL) ofs++;
                        end else begin
                            semi++;
                        end
                    end else if (c == CH_FLAT) begin
                        if (semi == 0) begin
                            semi = SEMI_TOP;
                            if (ofs > OFS_FLOOR) ofs--;
                        end else begin
                            semi--;
                        end
                    end else begin
                        phase = P_SPACE;
                        octave_char(c);
                    end
                end
                default: octave_char(c);
            endcase
            if (!last) begin
                return;
            end
            if (bad) begin
                p.freq = '0;
                p.ok   = 1'b0;
            end else begin
                oct = neg ? -digs : digs;
                if (oct == 0) oct = int'(OCT_DEF);
                oct += ofs;
                if (oct < int'(OCT_LO)) oct = int'(OCT_LO);
                if (oct > int'(OCT_HI)) oct = int'(OCT_HI);
                hz     = 32'(A1_Q8[semi]) << (oct - 1);
                p.freq = hz[FREQ_W-1:0];
                p.ok   = 1'b1;
            end
            pending.push_back(p);
            restart();
        endfunction

        function void check_result(logic [23:0] data, logic ok);
            t_pitch p;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result freq=%0d valid=%b", $time, data[21:0], ok);
                return;
            end
            p = pending.pop_front();
            if (p.ok) good_notes++; else bad_names++;
            if (data[21:0] !== p.freq) begin
                errors++;
                $display("%0t: freq_q8 expected %0d got %0d", $time, p.freq, data[21:0]);
            end
            if (data[23:22] !== 2'b00) begin
                errors++;
                $display("%0t: tdata pad expected 0 got %b", $time, data[23:22]);
            end
            if (ok !== p.ok) begin
                errors++;
                $display("%0t: valid_res expected %b got %b", $time, p.ok, ok);
            end
        endfunction
    endclass

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata  = '0;   // [7:0] ch
    logic        i_s_axis_tlast  = 1'b0; // last
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [23:0] o_m_axis_tdata;         // [21:0] freq_q8, [23:22] zero
    logic        o_m_axis_tuser;         // valid_res

    t_pitch_board board = new();
    int           src_idle_pct  = 0;
    int           snk_stall_pct = 0;
    int           sink_hold     = 0;
    int           chars_sent    = 0;

    note_name_to_frequency dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver: long hold-off when asked, otherwise random stalls
    initial begin
        forever begin
            @(posedge i_clk);
            if (sink_hold != 0) begin
                i_m_axis_tready <= 1'b0;
                sink_hold--;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            board.check_result(o_m_axis_tdata, o_m_axis_tuser);
        end
    end

    // Run limit
    initial begin
        #(12 * 200000);
        $display("RESULT: ERROR");
        $finish;
    end

    // Offer one character, with random idle cycles ahead of it
    task automatic send_char(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= c;
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        board.note_char(c, last);
        chars_sent++;
    endtask

    task automatic send_text(input string s, input bit close);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], close && (i == s.len() - 1));
        end
    endtask

    // Mostly well-formed names with random content
    task automatic send_random_name();
        logic [7:0] chars[$];
        string      letters;
        logic [7:0] acc;
        int         n;
        int         ws;
        letters = "ABCDEFGabcdefg";
        if ($urandom_range(9) != 0) begin
            chars.push_back(letters[$urandom_range(13)]);
        end else begin
            chars.push_back(8'($urandom_range(255)));
        end
        // occasional long accidental run to wrap the semitone and move the octave
        if ($urandom_range(19) == 0) begin
            acc = $urandom_range(1) ? CH_SHARP : CH_FLAT;
            repeat ($urandom_range(45, 30)) chars.push_back(acc);
        end else begin
            repeat ($urandom_range(3)) chars.push_back($urandom_range(1) ? CH_SHARP : CH_FLAT);
        end
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(2, 1)) begin
                ws = $urandom_range(5);
                chars.push_back(ws == 5 ? CH_SPACE : 8'(CH_TAB + ws));
            end
        end
        if ($urandom_range(4) == 0) begin
            chars.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
        end
        n = ($urandom_range(9) == 0) ? $urandom_range(4, 3) : $urandom_range(2);
        repeat (n) chars.push_back(8'(CH_ZERO + $urandom_range(9)));
        if ($urandom_range(6) == 0) begin
            repeat ($urandom_range(2, 1)) chars.push_back(8'($urandom_range(255)));
        end
        foreach (chars[i]) begin
            send_char(chars[i], i == chars.size() - 1);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed names: plain letter, case, bad letter, clamping, 'B' ending
        // accidentals, NUL, overflow, byte extremes
        send_text("A", 1);
        send_text("g#8", 1);
        send_text("Cb0", 1);
        send_text("H2", 1);
        send_text("B#-1", 1);
        send_text("eB5", 1);
        send_text("F", 0);
        send_char(8'h00, 0);
        send_text("9", 1);
        send_text("D 999", 1);
        send_char(8'hFF, 1);
        send_char(8'h00, 1);

        // Random phases: none, sender idle, receiver stall, both light
        for (int ph = 0; ph < 4; ph++) begin
            int target;
            case (ph)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 83; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 83; end
                default: begin src_idle_pct = 9; snk_stall_pct = 9; end
            endcase
            // back up the output while the sender keeps going
            if (ph == 0) sink_hold = 300;
            target = chars_sent + 235;
            while (chars_sent < target) begin
                if ($urandom_range(6) == 0) begin
                    repeat ($urandom_range(4, 1)) begin
                        send_char(8'($urandom_range(255)), $urandom_range(3) == 0);
                    end
                end else begin
                    send_random_name();
                end
            end
        end
        i_s_axis_tvalid <= 1'b0;

        // Drain
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Sent %0d characters; checked %0d notes and %0d rejected names",
                 chars_sent, board.good_notes, board.bad_names);
        $display("under idle, stall and long backpressure phases.");
        if (board.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
